// ===== rtl/centered_moving_average_macros.svh =====
// assertion macros shared by the moving average rtl
`ifndef CENTERED_MOVING_AVERAGE_MACROS_SVH
`define CENTERED_MOVING_AVERAGE_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication, off during reset
`define CMA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cma assertion failed");
// next-cycle implication, off during reset
`define CMA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cma assertion failed");
`else
`define CMA_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define CMA_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/cma_pkg.sv =====
// shared constants for the centered moving average
package cma_pkg;

    // width and reset value of the window length register
    localparam int         WIN_BITS  = 7;
    localparam logic [6:0] WIN_RESET = 7'd5;

endpackage

// ===== rtl/cma_sample_if.sv =====
// sample channel: valid/ready with one complex sample per request
interface cma_sample_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_real;
    logic signed [SAMPLE_BITS-1:0] sample_imag;
    logic                          final_sample;

    modport source (output valid, output sample_real, output sample_imag,
                    output final_sample, input ready);
    modport sink   (input valid, input sample_real, input sample_imag,
                    input final_sample, output ready);
endinterface

// ===== rtl/cma_mean_if.sv =====
// mean channel: valid/ready with one complex mean per request
interface cma_mean_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] mean_real;
    logic signed [SAMPLE_BITS-1:0] mean_imag;
    logic                          final_result;

    modport source (output valid, output mean_real, output mean_imag,
                    output final_result, input ready);
    modport sink   (input valid, input mean_real, input mean_imag,
                    input final_result, output ready);
endinterface

// ===== rtl/cma_history.sv =====
// sample history memory, one write port and one registered read port
module cma_history #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32,
    parameter int ABITS = 6
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [ABITS-1:0] i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [ABITS-1:0] i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read port, old data on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/cma_divider.sv =====
// two-lane restoring divider, one quotient bit per cycle, round to nearest
module cma_divider #(
    parameter int SAMPLE_BITS = 16,
    parameter int SUM_BITS    = 23,
    parameter int CNT_BITS    = 7
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic signed [SUM_BITS-1:0]    i_sum_real,
    input  logic signed [SUM_BITS-1:0]    i_sum_imag,
    input  logic [CNT_BITS-1:0]           i_count,
    output logic                          o_busy,
    output logic                          o_done,
    output logic signed [SAMPLE_BITS-1:0] o_mean_real,
    output logic signed [SAMPLE_BITS-1:0] o_mean_imag
);

    localparam int STEP_BITS = $clog2(SUM_BITS + 1);
    localparam logic [SUM_BITS-1:0] POS_LIM = SUM_BITS'((1 << (SAMPLE_BITS - 1)) - 1);
    localparam logic [SUM_BITS-1:0] NEG_LIM = SUM_BITS'(1 << (SAMPLE_BITS - 1));

    logic                 r_busy;
    logic                 r_done;
    logic [STEP_BITS-1:0] r_step;
    logic [CNT_BITS-1:0]  r_count;
    logic [1:0]           r_neg;
    logic [SUM_BITS-1:0]  r_dvd [2];
    logic [CNT_BITS-1:0]  r_rem [2];

    logic [SUM_BITS-1:0]  n_dvd [2];
    logic [CNT_BITS-1:0]  n_rem [2];
    logic [SUM_BITS-1:0]  mag   [2];
    logic signed [SAMPLE_BITS-1:0] mean [2];
    logic signed [SUM_BITS-1:0]    sum_in [2];
    logic [CNT_BITS:0]    shifted;
    logic                 ge;

    assign sum_in[0] = i_sum_real;
    assign sum_in[1] = i_sum_imag;

    // magnitudes with the half-count rounding bias
    always_comb begin
        for (int l = 0; l < 2; l++) begin
            mag[l] = (sum_in[l] < 0) ? SUM_BITS'(-sum_in[l]) : SUM_BITS'(sum_in[l]);
            mag[l] = mag[l] + SUM_BITS'(i_count >> 1);
        end
    end

    // one restoring step per lane
    always_comb begin
        shifted = '0;
        ge      = 1'b0;
        for (int l = 0; l < 2; l++) begin
            shifted  = {r_rem[l], r_dvd[l][SUM_BITS-1]};
            ge       = (shifted >= {1'b0, r_count});
            n_rem[l] = ge ? CNT_BITS'(shifted - {1'b0, r_count})
                          : CNT_BITS'(shifted);
            n_dvd[l] = {r_dvd[l][SUM_BITS-2:0], ge};
        end
    end

    // sequencing of the steps
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= STEP_BITS'(SUM_BITS);
            end else if (r_busy) begin
                r_step <= r_step - 1'b1;
                if (r_step == STEP_BITS'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // operand and partial result registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_count <= i_count;
            for (int l = 0; l < 2; l++) begin
                r_dvd[l] <= mag[l];
                r_rem[l] <= '0;
                r_neg[l] <= (sum_in[l] < 0);
            end
        end else if (r_busy) begin
            for (int l = 0; l < 2; l++) begin
                r_dvd[l] <= n_dvd[l];
                r_rem[l] <= n_rem[l];
            end
        end
    end

    // sign restore and saturation
    always_comb begin
        for (int l = 0; l < 2; l++) begin
            if (r_neg[l]) begin
                mean[l] = (r_dvd[l] > NEG_LIM) ? SAMPLE_BITS'(NEG_LIM)
                                               : SAMPLE_BITS'(-r_dvd[l]);
            end else begin
                mean[l] = (r_dvd[l] > POS_LIM) ? SAMPLE_BITS'(POS_LIM)
                                               : SAMPLE_BITS'(r_dvd[l]);
            end
        end
    end

    assign o_busy      = r_busy;
    assign o_done      = r_done;
    assign o_mean_real = mean[0];
    assign o_mean_imag = mean[1];

endmodule

// ===== rtl/centered_moving_average.sv =====
// centered moving average with edge shrinking, top level and sequencer
//
//  channel   dir  handshake     payload
//  i_sample  in   valid/ready   sample_real, sample_imag, final_sample
//  o_mean    out  valid/ready   mean_real, mean_imag, final_result
//  i_cfg     in   write enable  window length, 7 bits
//
//  a sample goes through ST_UPD and ST_EMIT to reach the shared divider,
//  then ST_DIV, then ST_OUT for the output
//  each extra mean of a final flush adds a history read per dropped sample
//  reset is synchronous; the history memory is not cleared
//  a stalled mean holds the block until it is taken
module centered_moving_average #(
    parameter int MAX_WINDOW  = 64,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    cma_sample_if.sink                   i_sample,
    cma_mean_if.source                   o_mean,
    input  logic                         i_cfg_wr_en,
    input  logic [cma_pkg::WIN_BITS-1:0] i_cfg_wr_data
);

    `include "centered_moving_average_macros.svh"

    localparam int SLOT_BITS = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int SW1       = SLOT_BITS + 1;
    localparam int CNT_BITS  = $clog2(MAX_WINDOW + 1);
    localparam int SUM_BITS  = SAMPLE_BITS + CNT_BITS;
    localparam int CMP_BITS  = (CNT_BITS > cma_pkg::WIN_BITS) ? CNT_BITS : cma_pkg::WIN_BITS;

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_UPD      = 3'd1;
    localparam logic [2:0] ST_EMIT     = 3'd2;
    localparam logic [2:0] ST_DROP_RD  = 3'd3;
    localparam logic [2:0] ST_DROP_SUB = 3'd4;
    localparam logic [2:0] ST_DIV      = 3'd5;
    localparam logic [2:0] ST_OUT      = 3'd6;

    function automatic logic [SLOT_BITS-1:0] f_wrap(input logic [SW1-1:0] a);
        logic [SW1-1:0] w;
        w = (a >= SW1'(MAX_WINDOW)) ? a - SW1'(MAX_WINDOW) : a;
        return SLOT_BITS'(w);
    endfunction

    // control state
    logic [2:0]                   r_state;
    logic [cma_pkg::WIN_BITS-1:0] r_win_len;
    logic signed [SUM_BITS-1:0]   r_sum_real;
    logic signed [SUM_BITS-1:0]   r_sum_imag;
    logic [SLOT_BITS-1:0]         r_slot;
    logic [CNT_BITS-1:0]          r_seen;
    logic                         r_full;
    logic                         r_fin;
    logic                         r_flush;
    logic                         r_emit_fin;
    logic [CNT_BITS-1:0]          r_q;
    logic [CNT_BITS-1:0]          r_drop;

    // payload registers
    logic signed [SAMPLE_BITS-1:0] r_x_real;
    logic signed [SAMPLE_BITS-1:0] r_x_imag;
    logic signed [SUM_BITS-1:0]    r_fsum_real;
    logic signed [SUM_BITS-1:0]    r_fsum_imag;
    logic signed [SAMPLE_BITS-1:0] r_out_real;
    logic signed [SAMPLE_BITS-1:0] r_out_imag;
    logic                          r_out_fin;

    logic [CMP_BITS-1:0]           win_ext;
    logic [CNT_BITS-1:0]           win_eff;
    logic [CNT_BITS-1:0]           half;
    logic [CNT_BITS-1:0]           look;
    logic [CNT_BITS-1:0]           c_new;
    logic [CNT_BITS-1:0]           q_first;
    logic [CNT_BITS-1:0]           lo;
    logic                          need_drop;
    logic [CNT_BITS-1:0]           div_count;
    logic signed [SUM_BITS-1:0]    n_sum_real;
    logic signed [SUM_BITS-1:0]    n_sum_imag;
    logic signed [SAMPLE_BITS-1:0] rd_real;
    logic signed [SAMPLE_BITS-1:0] rd_imag;
    logic                          in_req;
    logic                          out_req;
    logic                          div_start;
    logic                          div_busy;
    logic                          div_done;
    logic signed [SAMPLE_BITS-1:0] div_real;
    logic signed [SAMPLE_BITS-1:0] div_imag;
    logic                          mem_wr_en;
    logic                          mem_rd_en;
    logic [SLOT_BITS-1:0]          mem_rd_addr;
    logic [SLOT_BITS-1:0]          old_addr;
    logic [SLOT_BITS-1:0]          drop_addr;
    logic [2*SAMPLE_BITS-1:0]      mem_rd_data;

    // effective window and its split around the centre
    always_comb begin
        win_ext = CMP_BITS'(r_win_len);
        if (win_ext == '0) begin
            win_ext = CMP_BITS'(1);
        end else if (win_ext > CMP_BITS'(MAX_WINDOW)) begin
            win_ext = CMP_BITS'(MAX_WINDOW);
        end
        win_eff = CNT_BITS'(win_ext);
        half    = win_eff >> 1;
        look    = win_eff - CNT_BITS'(1) - half;
    end

    assign in_req  = i_sample.valid && i_sample.ready;
    assign out_req = o_mean.valid && o_mean.ready;

    // history addressing: slot leaving the window, and oldest held slots
    assign old_addr  = f_wrap({1'b0, r_slot} + SW1'(MAX_WINDOW) - SW1'(win_eff));
    assign drop_addr = f_wrap({1'b0, r_slot} + SW1'(MAX_WINDOW) - SW1'(r_seen)
                              + SW1'(r_drop));
    assign mem_wr_en   = in_req;
    assign mem_rd_en   = in_req || (r_state == ST_DROP_RD);
    assign mem_rd_addr = (r_state == ST_IDLE) ? old_addr : drop_addr;
    assign rd_real     = $signed(mem_rd_data[2*SAMPLE_BITS-1:SAMPLE_BITS]);
    assign rd_imag     = $signed(mem_rd_data[SAMPLE_BITS-1:0]);

    cma_history #(
        .DEPTH (MAX_WINDOW),
        .WIDTH (2 * SAMPLE_BITS),
        .ABITS (SLOT_BITS)
    ) u_history (
        .i_clk     (i_clk),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (r_slot),
        .i_wr_data ({i_sample.sample_real, i_sample.sample_imag}),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (mem_rd_data)
    );

    // running sum update, with the leaving sample removed once the window is full
    always_comb begin
        n_sum_real = r_sum_real + SUM_BITS'(r_x_real);
        n_sum_imag = r_sum_imag + SUM_BITS'(r_x_imag);
        if (r_full) begin
            n_sum_real = n_sum_real - SUM_BITS'(rd_real);
            n_sum_imag = n_sum_imag - SUM_BITS'(rd_imag);
        end
        c_new   = r_full ? r_seen : r_seen + CNT_BITS'(1);
        q_first = (c_new - CNT_BITS'(1) >= look) ? c_new - CNT_BITS'(1) - look : '0;
    end

    // span of the current flush position
    always_comb begin
        lo        = (r_q >= half) ? r_q - half : '0;
        need_drop = r_flush && (r_drop < lo);
        div_count = r_flush ? r_seen - lo : r_seen;
        div_start = (r_state == ST_EMIT) && !need_drop;
    end

    cma_divider #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .SUM_BITS    (SUM_BITS),
        .CNT_BITS    (CNT_BITS)
    ) u_divider (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_sum_real  (r_fsum_real),
        .i_sum_imag  (r_fsum_imag),
        .i_count     (div_count),
        .o_busy      (div_busy),
        .o_done      (div_done),
        .o_mean_real (div_real),
        .o_mean_imag (div_imag)
    );

    // sequencer and stream state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_win_len  <= cma_pkg::WIN_RESET;
            r_sum_real <= '0;
            r_sum_imag <= '0;
            r_slot     <= '0;
            r_seen     <= '0;
            r_full     <= 1'b0;
            r_fin      <= 1'b0;
            r_flush    <= 1'b0;
            r_emit_fin <= 1'b0;
            r_q        <= '0;
            r_drop     <= '0;
        end else if (i_cfg_wr_en) begin
            r_win_len  <= i_cfg_wr_data;
            r_sum_real <= '0;
            r_sum_imag <= '0;
            r_slot     <= '0;
            r_seen     <= '0;
            r_flush    <= 1'b0;
            r_state    <= ST_IDLE;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (in_req) begin
                        r_full  <= (r_seen == win_eff);
                        r_fin   <= i_sample.final_sample;
                        r_slot  <= (r_slot == SLOT_BITS'(MAX_WINDOW - 1))
                                   ? '0 : r_slot + SLOT_BITS'(1);
                        r_state <= ST_UPD;
                    end
                end
                ST_UPD: begin
                    r_sum_real <= n_sum_real;
                    r_sum_imag <= n_sum_imag;
                    r_seen     <= c_new;
                    r_flush    <= r_fin;
                    r_q        <= q_first;
                    r_drop     <= '0;
                    if (r_fin || (c_new > look)) begin
                        r_state <= ST_EMIT;
                    end else begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_EMIT: begin
                    if (need_drop) begin
                        r_state <= ST_DROP_RD;
                    end else begin
                        r_emit_fin <= r_flush && (r_q == r_seen - CNT_BITS'(1));
                        r_state    <= ST_DIV;
                    end
                end
                ST_DROP_RD: begin
                    r_state <= ST_DROP_SUB;
                end
                ST_DROP_SUB: begin
                    r_drop  <= r_drop + CNT_BITS'(1);
                    r_state <= ST_EMIT;
                end
                ST_DIV: begin
                    if (div_done) begin
                        r_state <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (out_req) begin
                        if (!r_flush) begin
                            r_state <= ST_IDLE;
                        end else if (r_emit_fin) begin
                            // end of sequence, start afresh
                            r_sum_real <= '0;
                            r_sum_imag <= '0;
                            r_slot     <= '0;
                            r_seen     <= '0;
                            r_flush    <= 1'b0;
                            r_state    <= ST_IDLE;
                        end else begin
                            r_q     <= r_q + CNT_BITS'(1);
                            r_state <= ST_EMIT;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // sample, flush sum and result holding registers
    always_ff @(posedge i_clk) begin
        if (in_req) begin
            r_x_real <= i_sample.sample_real;
            r_x_imag <= i_sample.sample_imag;
        end
        if (r_state == ST_UPD) begin
            r_fsum_real <= n_sum_real;
            r_fsum_imag <= n_sum_imag;
        end else if (r_state == ST_DROP_SUB) begin
            r_fsum_real <= r_fsum_real - SUM_BITS'(rd_real);
            r_fsum_imag <= r_fsum_imag - SUM_BITS'(rd_imag);
        end
        if ((r_state == ST_DIV) && div_done) begin
            r_out_real <= div_real;
            r_out_imag <= div_imag;
            r_out_fin  <= r_emit_fin;
        end
    end

    assign i_sample.ready      = (r_state == ST_IDLE);
    assign o_mean.valid        = (r_state == ST_OUT);
    assign o_mean.mean_real    = r_out_real;
    assign o_mean.mean_imag    = r_out_imag;
    assign o_mean.final_result = r_out_fin;

    // checks on the sequencer
    `CMA_ASSERT_IMP(a_seen_in_window, i_clk, i_rst_n, 1'b1, r_seen <= win_eff)
    `CMA_ASSERT_IMP(a_done_in_div, i_clk, i_rst_n, div_done, r_state == ST_DIV)
    `CMA_ASSERT_IMP(a_no_start_busy, i_clk, i_rst_n, div_start, !div_busy)
    `CMA_ASSERT_NXT(a_clear_after_final, i_clk, i_rst_n,
                    out_req && o_mean.final_result && !i_cfg_wr_en,
                    (r_seen == '0) && (r_sum_real == '0) && (r_sum_imag == '0))

endmodule
